// ===== hdl/fixed_timestep_accumulator_top_macros.svh =====
// Assertion macros for the fixed timestep accumulator.
// Used by fixed_timestep_accumulator_top; no other dependencies.
`ifndef FIXED_TIMESTEP_ACCUMULATOR_TOP_MACROS_SVH
`define FIXED_TIMESTEP_ACCUMULATOR_TOP_MACROS_SVH

// same-cycle implication
`define FTA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FTA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fta_pkg.sv =====
// Package for the fixed timestep accumulator: widths, types, codes, resets.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package fta_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int SIM_TIME_WIDTH = 48;
  localparam int REG_W          = 26;
  localparam int BL_W           = REG_W + 1;
  localparam int STAMP_W        = 32;
  localparam int SHORT_W        = 20;
  localparam int ALPHA_W        = FRAC_BITS + 1;
  localparam int CNT_W          = 6;
  localparam int DIV_CNT_W      = $clog2(FRAC_BITS);
  localparam int RAW_KEEP       = REG_W - FRAC_BITS;
  localparam int SUB_W          = BL_W + 1;

  typedef logic [REG_W-1:0]          reg_t;
  typedef logic [0:0]                cfg_index_t;
  typedef logic [STAMP_W-1:0]        stamp_t;
  typedef logic [BL_W-1:0]           backlog_t;
  typedef logic [SIM_TIME_WIDTH-1:0] sim_t;
  typedef logic [ALPHA_W-1:0]        alpha_t;
  typedef logic [SHORT_W-1:0]        short_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [FRAC_BITS-1:0]      quo_t;

  localparam reg_t     TICK_PERIOD_RESET = REG_W'(1092267);
  localparam reg_t     FRAME_CLAMP_RESET = REG_W'(1638400);
  localparam short_t   SHORTEST_RESET    = SHORT_W'(1000000);
  localparam backlog_t BL_MAX            = {BL_W{1'b1}};
  localparam cnt_t     MAX_TICKS         = CNT_W'(63);
  localparam alpha_t   ONE               = alpha_t'(1) << FRAC_BITS;

  localparam cfg_index_t REG_TICK_PERIOD = 1'b0;
  localparam cfg_index_t REG_FRAME_CLAMP = 1'b1;

  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_STEP    = 1'b1;
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_STAT = 6'b000010,
    S_ADD  = 6'b000100,
    S_TICK = 6'b001000,
    S_DIV  = 6'b010000,
    S_END  = 6'b100000
  } state_t;

endpackage

// ===== hdl/fta_in_if.sv =====
// Input channel: valid/ready handshake carrying one timestamp word.
// Depends on fta_pkg.
`timescale 1ns / 1ps

interface fta_in_if;
  import fta_pkg::*;

  logic   valid;
  logic   ready;
  logic   opcode;
  stamp_t now_ms;

  modport source (output valid, output opcode, output now_ms, input ready);
  modport sink   (input valid, input opcode, input now_ms, output ready);
endinterface

// ===== hdl/fta_out_if.sv =====
// Output channel: valid/ready handshake carrying one tick or end word.
// Depends on fta_pkg.
`timescale 1ns / 1ps

interface fta_out_if;
  import fta_pkg::*;

  logic     valid;
  logic     ready;
  logic     kind;
  sim_t     sim_time;
  alpha_t   alpha;
  logic     last;
  stamp_t   longest_frame_ms;
  short_t   shortest_frame_ms;
  backlog_t largest_backlog;

  modport source (
    output valid, output kind, output sim_time, output alpha, output last,
    output longest_frame_ms, output shortest_frame_ms, output largest_backlog,
    input ready
  );
  modport sink (
    input valid, input kind, input sim_time, input alpha, input last,
    input longest_frame_ms, input shortest_frame_ms, input largest_backlog,
    output ready
  );
endinterface

// ===== hdl/fixed_timestep_accumulator_top.sv =====
// Fixed timestep accumulator. A restart word only records its timestamp, and
// the next word can be taken in the following cycle. A step word runs through
// frame stats and clamp, the backlog add, the tick loop (at most 63 tick
// words) and its exit, then a restoring division for alpha (skipped when the
// tick limit is reached, which leaves alpha zero) and the end word before the
// next word can be taken. One 28-bit subtractor is shared by the tick loop
// and the division. Output stalls hold the tick loop and the end word. The
// input is not ready while a step runs.
// Depends on fta_pkg, fta_in_if, fta_out_if and the assertion macro header.
`timescale 1ns / 1ps

module fixed_timestep_accumulator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  fta_pkg::cfg_index_t wr_index,
  input  fta_pkg::reg_t      wr_data,
  fta_in_if.sink             in_ch,
  fta_out_if.source          out_ch
);
  import fta_pkg::*;

  state_t   state;
  reg_t     tick_period;
  reg_t     frame_clamp;
  stamp_t   last_stamp;
  backlog_t backlog;
  sim_t     sim_clock;
  stamp_t   longest_seen;
  short_t   shortest_seen;
  backlog_t backlog_peak;
  cnt_t     tick_cnt;
  logic     out_valid;

  stamp_t   raw;
  reg_t     frame;
  reg_t     rem;
  quo_t     quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  alpha_t   alpha_r;

  logic     o_kind;
  sim_t     o_sim_time;
  alpha_t   o_alpha;
  logic     o_last;
  stamp_t   o_longest;
  short_t   o_shortest;
  backlog_t o_largest;

  logic [SUB_W-1:0] sub_a;
  logic [SUB_W:0]   diff;
  logic             borrow;
  logic             slot_free;
  logic             tick_go;
  logic             in_acc;
  logic             clamp_hit;
  reg_t             frame_lo;
  logic [SUB_W-1:0] sum;
  backlog_t         peak_new;
  quo_t             quo_next;

  // shared compare/subtract unit
  always_comb begin
    if (state == S_DIV) begin
      sub_a = {1'b0, rem, 1'b0};
    end else begin
      sub_a = {1'b0, backlog};
    end
    diff   = {1'b0, sub_a} - {{(SUB_W + 1 - REG_W){1'b0}}, tick_period};
    borrow = diff[SUB_W];
  end

  assign slot_free = !out_valid || out_ch.ready;
  assign tick_go   = (tick_cnt != MAX_TICKS) && !borrow;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign frame_lo  = {raw[RAW_KEEP-1:0], {FRAC_BITS{1'b0}}};
  assign clamp_hit = (|raw[STAMP_W-1:RAW_KEEP]) || (frame_lo > frame_clamp);
  assign sum       = {1'b0, backlog} + {{(SUB_W - REG_W){1'b0}}, frame};
  assign peak_new  = (backlog > backlog_peak) ? backlog : backlog_peak;
  assign quo_next  = {quo[FRAC_BITS-2:0], ~borrow};

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      tick_period   <= TICK_PERIOD_RESET;
      frame_clamp   <= FRAME_CLAMP_RESET;
      last_stamp    <= '0;
      backlog       <= '0;
      sim_clock     <= '0;
      longest_seen  <= '0;
      shortest_seen <= SHORTEST_RESET;
      backlog_peak  <= '0;
      tick_cnt      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_TICK_PERIOD: tick_period <= wr_data;
          REG_FRAME_CLAMP: frame_clamp <= wr_data;
        endcase
      end
      if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            last_stamp <= in_ch.now_ms;
            if (in_ch.opcode == OP_STEP) begin
              state <= S_STAT;
            end
          end
        end
        S_STAT: begin
          if (raw > longest_seen) begin
            longest_seen <= raw;
          end
          if ((raw != '0) && (raw[STAMP_W-1:SHORT_W] == '0) &&
              (raw[SHORT_W-1:0] < shortest_seen)) begin
            shortest_seen <= raw[SHORT_W-1:0];
          end
          state <= S_ADD;
        end
        S_ADD: begin
          backlog  <= sum[BL_W] ? BL_MAX : sum[BL_W-1:0];
          tick_cnt <= '0;
          state    <= S_TICK;
        end
        S_TICK: begin
          if (tick_go) begin
            if (slot_free) begin
              backlog_peak <= peak_new;
              backlog      <= diff[BL_W-1:0];
              sim_clock    <= sim_clock + SIM_TIME_WIDTH'(tick_period);
              tick_cnt     <= tick_cnt + 1'b1;
              out_valid    <= 1'b1;
            end
          end else if (borrow) begin
            state <= S_DIV;
          end else begin
            state <= S_END;
          end
        end
        S_DIV: begin
          if (div_cnt == '0) begin
            state <= S_END;
          end
        end
        S_END: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath and output word
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        raw <= in_ch.now_ms - last_stamp;
      end
      S_STAT: begin
        frame <= clamp_hit ? frame_clamp : frame_lo;
      end
      S_TICK: begin
        if (tick_go) begin
          if (slot_free) begin
            o_kind     <= KIND_TICK;
            o_sim_time <= sim_clock;
            o_alpha    <= '0;
            o_last     <= 1'b0;
            o_longest  <= longest_seen;
            o_shortest <= shortest_seen;
            o_largest  <= peak_new;
          end
        end else begin
          rem     <= backlog[REG_W-1:0];
          quo     <= '0;
          div_cnt <= DIV_CNT_W'(FRAC_BITS - 1);
          alpha_r <= '0;
        end
      end
      S_DIV: begin
        rem     <= borrow ? sub_a[REG_W-1:0] : diff[REG_W-1:0];
        quo     <= quo_next;
        div_cnt <= div_cnt - 1'b1;
        if (div_cnt == '0) begin
          alpha_r <= ONE - {1'b0, quo_next};
        end
      end
      S_END: begin
        if (slot_free) begin
          o_kind     <= KIND_END;
          o_sim_time <= sim_clock;
          o_alpha    <= alpha_r;
          o_last     <= 1'b1;
          o_longest  <= longest_seen;
          o_shortest <= shortest_seen;
          o_largest  <= backlog_peak;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ch.ready              = (state == S_IDLE);
  assign out_ch.valid             = out_valid;
  assign out_ch.kind              = o_kind;
  assign out_ch.sim_time          = o_sim_time;
  assign out_ch.alpha             = o_alpha;
  assign out_ch.last              = o_last;
  assign out_ch.longest_frame_ms  = o_longest;
  assign out_ch.shortest_frame_ms = o_shortest;
  assign out_ch.largest_backlog   = o_largest;

`include "fixed_timestep_accumulator_top_macros.svh"

  `FTA_ASSERT_IMP(a_div_rem_below_period, clk, rst, state == S_DIV,
    rem < tick_period, "remainder not below period")
  `FTA_ASSERT_IMP(a_end_word_fields, clk, rst, out_ch.valid && out_ch.kind == KIND_END,
    out_ch.last && out_ch.alpha <= ONE, "bad end word")
  `FTA_ASSERT_IMP(a_tick_word_fields, clk, rst, out_ch.valid && out_ch.kind == KIND_TICK,
    !out_ch.last && out_ch.alpha == '0, "bad tick word")
  `FTA_ASSERT_NXT(a_busy_after_step, clk, rst, in_acc && in_ch.opcode == OP_STEP,
    !in_ch.ready, "ready during step")

endmodule
